>>> rtl/tchf_pkg.sv
// Package with the parser phases, token kinds and shared types.
`timescale 1ns / 1ps
package tchf_pkg;

    typedef enum logic [4:0] {
        PH_FIXED, PH_SID, PH_CSLEN_HI, PH_CSLEN_LO, PH_CS_HI, PH_CS_LO,
        PH_COMP_LEN, PH_COMP, PH_EXTLEN_HI, PH_EXTLEN_LO, PH_ET_HI, PH_ET_LO,
        PH_EL_HI, PH_EL_LO, PH_BODY_SKIP, PH_GRP_LEN_HI, PH_GRP_LEN_LO,
        PH_GRP_HI, PH_GRP_LO, PH_PF_LEN, PH_PF, PH_SV_LEN, PH_SV_HI, PH_SV_LO,
        PH_DONE, PH_REJECT
    } phase_t;

    localparam logic [2:0] KIND_VERSION = 3'd0;
    localparam logic [2:0] KIND_CIPHER  = 3'd1;
    localparam logic [2:0] KIND_EXT     = 3'd2;
    localparam logic [2:0] KIND_CURVE   = 3'd3;
    localparam logic [2:0] KIND_POINT   = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_HELLO = 2'd1;
    localparam logic [1:0] STATUS_TRUNC     = 2'd2;

    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_GROUPS      = 16'h000a;
    localparam logic [15:0] EXT_POINTS      = 16'h000b;
    localparam logic [15:0] EXT_VERSIONS    = 16'h002b;
    localparam logic [15:0] VER_TLS13       = 16'h0304;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_value;
        logic        end_of_record;
        logic [1:0]  parse_status;
        logic        offers_tls13;
    } token_t;

    // Up to two tokens per byte travel from the parser to the queue.
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        token_t tok0;
        token_t tok1;
    } tok_pair_t;

    function automatic logic grease_code(input logic [15:0] v);
        return (v[11:8] == 4'ha) && (v[3:0] == 4'ha) && (v[15:8] == v[7:0]);
    endfunction

endpackage

>>> rtl/tchf_if.sv
// Valid/ready stream interfaces for record bytes and tokens.
`timescale 1ns / 1ps
interface tchf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;
    modport source (output valid, data_byte, is_final, input ready);
    modport sink (input valid, data_byte, is_final, output ready);
endinterface

interface tchf_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_value;
    logic        end_of_record;
    logic [1:0]  parse_status;
    logic        offers_tls13;
    modport source (output valid, token_kind, token_value, end_of_record, parse_status,
                    offers_tls13, input ready);
    modport sink (input valid, token_kind, token_value, end_of_record, parse_status,
                  offers_tls13, output ready);
endinterface

>>> rtl/tchf_parser.sv
// Front end: byte parser that classifies record bytes into tokens.
`timescale 1ns / 1ps
module tchf_parser
    import tchf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       is_final,
    output tok_pair_t  toks
);

    phase_t      phase_reg, phase_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] sect_reg, sect_next;
    logic [15:0] ext_reg, ext_next;
    logic [15:0] body_reg, body_next;
    logic [15:0] list_reg, list_next;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  held_reg, held_next;
    logic        t13_reg, t13_next;
    logic [1:0]  status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIXED;
            offset_reg <= '0;
            sect_reg   <= '0;
            ext_reg    <= '0;
            body_reg   <= '0;
            list_reg   <= '0;
            etype_reg  <= '0;
            held_reg   <= '0;
            t13_reg    <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            sect_reg   <= sect_next;
            ext_reg    <= ext_next;
            body_reg   <= body_next;
            list_reg   <= list_next;
            etype_reg  <= etype_next;
            held_reg   <= held_next;
            t13_reg    <= t13_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        logic [15:0] word;
        logic        in_body;
        token_t      t;
        logic        emit;
        logic [1:0]  st;

        word = {held_reg, data_byte};
        phase_next  = phase_reg;
        offset_next = offset_reg;
        sect_next   = sect_reg;
        ext_next    = ext_reg;
        body_next   = body_reg;
        list_next   = list_reg;
        etype_next  = etype_reg;
        held_next   = held_reg;
        t13_next    = t13_reg;
        status_next = status_reg;
        t    = '0;
        emit = 1'b0;
        in_body = (phase_reg >= PH_BODY_SKIP) && (phase_reg <= PH_SV_LO);

        case (phase_reg)
            PH_FIXED:
            begin
                if ((offset_reg == 16'd0 && data_byte != REC_HANDSHAKE)
                    || (offset_reg == 16'd5 && data_byte != HS_CLIENT_HELLO))
                begin
                    status_next = STATUS_NOT_HELLO;
                    phase_next  = PH_REJECT;
                end
                else
                begin
                    if (offset_reg == 16'd9)
                        held_next = data_byte;
                    if (offset_reg == 16'd10)
                    begin
                        emit = 1'b1;
                        t.token_kind  = KIND_VERSION;
                        t.token_value = word;
                    end
                    if (offset_reg == 16'd43)
                    begin
                        sect_next  = {8'd0, data_byte};
                        phase_next = (data_byte != 8'd0) ? PH_SID : PH_CSLEN_HI;
                    end
                    if (offset_reg != 16'hffff)
                        offset_next = offset_reg + 16'd1;
                end
            end
            PH_SID, PH_COMP:
            begin
                sect_next = sect_reg - 16'd1;
                if (sect_next == 16'd0)
                    phase_next = (phase_reg == PH_SID) ? PH_CSLEN_HI : PH_EXTLEN_HI;
            end
            PH_CSLEN_HI:
            begin
                held_next  = data_byte;
                phase_next = PH_CSLEN_LO;
            end
            PH_EXTLEN_HI:
            begin
                held_next  = data_byte;
                phase_next = PH_EXTLEN_LO;
            end
            PH_CSLEN_LO:
            begin
                sect_next  = word;
                phase_next = (word != 16'd0) ? PH_CS_HI : PH_COMP_LEN;
            end
            PH_CS_HI:
            begin
                sect_next  = sect_reg - 16'd1;
                held_next  = data_byte;
                phase_next = (sect_next != 16'd0) ? PH_CS_LO : PH_COMP_LEN;
            end
            PH_CS_LO:
            begin
                sect_next = sect_reg - 16'd1;
                if (!grease_code(word))
                begin
                    emit = 1'b1;
                    t.token_kind  = KIND_CIPHER;
                    t.token_value = word;
                end
                phase_next = (sect_next != 16'd0) ? PH_CS_HI : PH_COMP_LEN;
            end
            PH_COMP_LEN:
            begin
                sect_next  = {8'd0, data_byte};
                phase_next = (data_byte != 8'd0) ? PH_COMP : PH_EXTLEN_HI;
            end
            PH_EXTLEN_LO:
            begin
                ext_next   = word;
                phase_next = (word != 16'd0) ? PH_ET_HI : PH_DONE;
            end
            PH_ET_HI, PH_ET_LO, PH_EL_HI, PH_EL_LO, PH_BODY_SKIP, PH_GRP_LEN_HI,
            PH_GRP_LEN_LO, PH_GRP_HI, PH_GRP_LO, PH_PF_LEN, PH_PF, PH_SV_LEN,
            PH_SV_HI, PH_SV_LO:
            begin
                ext_next = ext_reg - 16'd1;
                if (in_body)
                    body_next = body_reg - 16'd1;
                case (phase_reg)
                    PH_ET_HI:
                    begin
                        held_next  = data_byte;
                        phase_next = PH_ET_LO;
                    end
                    PH_ET_LO:
                    begin
                        etype_next = word;
                        phase_next = PH_EL_HI;
                    end
                    PH_EL_HI:
                    begin
                        held_next  = data_byte;
                        phase_next = PH_EL_LO;
                    end
                    PH_EL_LO:
                    begin
                        if (!grease_code(etype_reg))
                        begin
                            emit = 1'b1;
                            t.token_kind  = KIND_EXT;
                            t.token_value = etype_reg;
                        end
                        body_next = word;
                        if (word == 16'd0)
                            phase_next = PH_ET_HI;
                        else if (etype_reg == EXT_GROUPS && word >= 16'd2)
                            phase_next = PH_GRP_LEN_HI;
                        else if (etype_reg == EXT_POINTS)
                            phase_next = PH_PF_LEN;
                        else if (etype_reg == EXT_VERSIONS)
                            phase_next = PH_SV_LEN;
                        else
                            phase_next = PH_BODY_SKIP;
                    end
                    PH_GRP_LEN_HI:
                    begin
                        held_next  = data_byte;
                        phase_next = PH_GRP_LEN_LO;
                    end
                    PH_GRP_LEN_LO:
                    begin
                        list_next  = word;
                        phase_next = PH_GRP_HI;
                    end
                    PH_GRP_HI, PH_SV_HI:
                    begin
                        if (list_reg < 16'd2)
                            phase_next = PH_BODY_SKIP;
                        else
                        begin
                            list_next  = list_reg - 16'd2;
                            held_next  = data_byte;
                            phase_next = (phase_reg == PH_GRP_HI) ? PH_GRP_LO : PH_SV_LO;
                        end
                    end
                    PH_GRP_LO:
                    begin
                        if (!grease_code(word))
                        begin
                            emit = 1'b1;
                            t.token_kind  = KIND_CURVE;
                            t.token_value = word;
                        end
                        phase_next = PH_GRP_HI;
                    end
                    PH_SV_LO:
                    begin
                        if (word == VER_TLS13)
                            t13_next = 1'b1;
                        phase_next = PH_SV_HI;
                    end
                    PH_PF_LEN:
                    begin
                        list_next  = {8'd0, data_byte};
                        phase_next = PH_PF;
                    end
                    PH_SV_LEN:
                    begin
                        list_next  = {8'd0, data_byte};
                        phase_next = PH_SV_HI;
                    end
                    PH_PF:
                    begin
                        if (list_reg == 16'd0)
                            phase_next = PH_BODY_SKIP;
                        else
                        begin
                            list_next = list_reg - 16'd1;
                            emit = 1'b1;
                            t.token_kind  = KIND_POINT;
                            t.token_value = {8'd0, data_byte};
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (in_body && body_next == 16'd0)
                    phase_next = PH_ET_HI;
                if (ext_next == 16'd0)
                    phase_next = PH_DONE;
            end
            default:
            begin
            end
        endcase

        st = status_next;
        if (st == STATUS_OK && phase_next < PH_COMP_LEN)
            st = STATUS_TRUNC;

        // The end token always takes the second slot when a token was also emitted.
        toks = '0;
        toks.valid0 = emit;
        toks.tok0   = t;
        toks.valid1 = is_final;
        toks.tok1.token_kind    = KIND_END;
        toks.tok1.end_of_record = 1'b1;
        toks.tok1.parse_status  = st;
        toks.tok1.offers_tls13  = t13_next;

        if (is_final)
        begin
            phase_next  = PH_FIXED;
            offset_next = '0;
            sect_next   = '0;
            ext_next    = '0;
            body_next   = '0;
            list_next   = '0;
            etype_next  = '0;
            held_next   = '0;
            t13_next    = 1'b0;
            status_next = STATUS_OK;
        end
    end

endmodule

>>> rtl/tchf_queue.sv
// Back end: token queue that takes two tokens a cycle and sends one.
`timescale 1ns / 1ps
module tchf_queue
    import tchf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tok_pair_t  toks,
    output logic       has_room,
    tchf_tok_if.source tok_out
);

    token_t          mem [QDEPTH];
    logic [QAW-1:0]  wr_reg, rd_reg;
    logic [QAW:0]    count_reg;
    logic            pop;
    logic            w0, w1;
    logic [QAW-1:0]  wa1;
    logic [1:0]      nin;
    token_t          head;

    assign pop = tok_out.valid && tok_out.ready;
    assign w0  = push && (toks.valid0 || toks.valid1);
    assign w1  = push && toks.valid0 && toks.valid1;
    assign nin = {1'b0, w0} + {1'b0, w1};
    assign wa1 = wr_reg + QAW'(1);
    // Room for two tokens is needed before a byte is taken.
    assign has_room = count_reg <= (QAW+1)'(QDEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (w0)
            mem[wr_reg] <= toks.valid0 ? toks.tok0 : toks.tok1;
        if (w1)
            mem[wa1] <= toks.tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + QAW'(nin);
            if (pop)
                rd_reg <= rd_reg + QAW'(1);
            count_reg <= count_reg + (QAW+1)'(nin) - (QAW+1)'(pop);
        end
    end

    assign head = mem[rd_reg];
    assign tok_out.valid         = count_reg != '0;
    assign tok_out.token_kind    = head.token_kind;
    assign tok_out.token_value   = head.token_value;
    assign tok_out.end_of_record = head.end_of_record;
    assign tok_out.parse_status  = head.parse_status;
    assign tok_out.offers_tls13  = head.offers_tls13;

endmodule

>>> rtl/tls_client_hello_fingerprint.sv
// Top level of the ClientHello fingerprint token extractor.
// A token is queued when the byte that completes it is taken, and offered in order.
// Throughput: one byte per cycle while the four-entry token queue has room for two;
// a byte can yield two tokens, so sustained rate is set by the one-token-a-cycle output.
// Reset: rst_n clears the parser to the record start and empties the queue.
`timescale 1ns / 1ps
module tls_client_hello_fingerprint
    import tchf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tchf_byte_if.sink  byte_in,
    tchf_tok_if.source tok_out
);

    tok_pair_t toks;
    logic      room;
    logic      step;

    assign byte_in.ready = room;
    assign step = byte_in.valid && room;

    tchf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (byte_in.data_byte),
        .is_final  (byte_in.is_final),
        .toks      (toks)
    );

    tchf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step),
        .toks     (toks),
        .has_room (room),
        .tok_out  (tok_out)
    );

endmodule

>>> rtl/tchf_checker.sv
// Port-level checker for the fingerprint block, bound to the top level.
`timescale 1ns / 1ps
module tchf_checker
    import tchf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  token_kind,
    input logic [15:0] token_value,
    input logic        end_of_record,
    input logic [1:0]  parse_status,
    input logic        offers_tls13
);

    // The input only stalls when tokens are waiting in the queue.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with an empty queue");

    a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (end_of_record == (token_kind == KIND_END)))
        else $error("end flag does not match kind");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> token_value == 16'd0)
        else $error("end token carries a value");

    a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_END |-> parse_status == STATUS_OK && !offers_tls13)
        else $error("status on a non-end token");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_value))
        else $error("stalled token changed");

endmodule

bind tls_client_hello_fingerprint tchf_checker u_tchf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (byte_in.valid),
    .in_ready      (byte_in.ready),
    .out_valid     (tok_out.valid),
    .out_ready     (tok_out.ready),
    .token_kind    (tok_out.token_kind),
    .token_value   (tok_out.token_value),
    .end_of_record (tok_out.end_of_record),
    .parse_status  (tok_out.parse_status),
    .offers_tls13  (tok_out.offers_tls13)
);

>>> tb/testbench.sv
// Self-checking testbench for the ClientHello fingerprint token extractor.
`timescale 1ns / 1ps
module testbench;
    import tchf_pkg::*;

    logic clk;
    logic rst_n;

    tchf_byte_if byte_in ();
    tchf_tok_if  tok_out ();

    tls_client_hello_fingerprint uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in.sink),
        .tok_out (tok_out.source)
    );

    typedef struct {
        logic [7:0] data;
        logic       fin;
        logic       has_tok;
        token_t     tok;
    } dir_row_t;

    localparam int NUM_DIR = 20;
    localparam token_t NO_TOK  = '{KIND_VERSION, 16'h0, 1'b0, STATUS_OK, 1'b0};
    localparam token_t END_NH  = '{KIND_END, 16'h0, 1'b1, STATUS_NOT_HELLO, 1'b0};
    localparam token_t END_TR  = '{KIND_END, 16'h0, 1'b1, STATUS_TRUNC, 1'b0};
    localparam token_t VER_TOK = '{KIND_VERSION, 16'h0303, 1'b0, STATUS_OK, 1'b0};

    dir_row_t dir_rows [NUM_DIR] = '{
        '{8'h17, 1'b1, 1'b1, END_NH},
        '{8'h16, 1'b1, 1'b1, END_TR},
        '{8'h16, 1'b0, 1'b0, NO_TOK},
        '{8'h03, 1'b0, 1'b0, NO_TOK},
        '{8'h01, 1'b0, 1'b0, NO_TOK},
        '{8'h00, 1'b0, 1'b0, NO_TOK},
        '{8'h00, 1'b0, 1'b0, NO_TOK},
        '{8'h02, 1'b1, 1'b1, END_NH},
        '{8'h16, 1'b0, 1'b0, NO_TOK},
        '{8'h03, 1'b0, 1'b0, NO_TOK},
        '{8'h01, 1'b0, 1'b0, NO_TOK},
        '{8'h00, 1'b0, 1'b0, NO_TOK},
        '{8'h40, 1'b0, 1'b0, NO_TOK},
        '{8'h01, 1'b0, 1'b0, NO_TOK},
        '{8'h00, 1'b0, 1'b0, NO_TOK},
        '{8'h00, 1'b0, 1'b0, NO_TOK},
        '{8'h3c, 1'b0, 1'b0, NO_TOK},
        '{8'h03, 1'b0, 1'b0, NO_TOK},
        '{8'h03, 1'b0, 1'b1, VER_TOK},
        '{8'hff, 1'b1, 1'b1, END_TR}
    };

    // Parser shadow state.
    phase_t      p_phase;
    logic [15:0] p_offset, p_section, p_ext, p_body, p_list, p_type;
    logic [7:0]  p_held;
    logic        p_tls13;
    logic [1:0]  p_status;

    token_t      pending_tokens [$];
    token_t      new_tokens [$];
    logic [7:0]  record_bytes [$];
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_cycles = 0;
    int          bytes_sent = 0;

    initial begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic grease(input logic [15:0] v);
        return v[15:8] == v[7:0] && v[3:0] == 4'ha;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [15:0] value,
                                 input logic eor, input logic [1:0] st, input logic t13);
        token_t t;
        t.token_kind    = kind;
        t.token_value   = value;
        t.end_of_record = eor;
        t.parse_status  = st;
        t.offers_tls13  = t13;
        new_tokens.push_back(t);
    endfunction

    function automatic void clear_parser();
        p_phase   = PH_FIXED;
        p_offset  = '0;
        p_section = '0;
        p_ext     = '0;
        p_body    = '0;
        p_list    = '0;
        p_type    = '0;
        p_held    = '0;
        p_tls13   = 1'b0;
        p_status  = STATUS_OK;
    endfunction

    function automatic void extension_byte(input logic [7:0] b);
        phase_t      ph;
        phase_t      nx;
        logic        in_body;
        logic [15:0] v;
        ph = p_phase;
        nx = ph;
        in_body = (ph >= PH_BODY_SKIP) && (ph <= PH_SV_LO);
        v = {p_held, b};
        p_ext = p_ext - 16'd1;
        if (in_body)
            p_body = p_body - 16'd1;
        case (ph)
            PH_ET_HI: begin p_held = b; nx = PH_ET_LO; end
            PH_ET_LO: begin p_type = v; nx = PH_EL_HI; end
            PH_EL_HI: begin p_held = b; nx = PH_EL_LO; end
            PH_EL_LO:
            begin
                if (!grease(p_type))
                    emit(KIND_EXT, p_type, 1'b0, STATUS_OK, 1'b0);
                p_body = v;
                if (p_body == 0)
                    nx = PH_ET_HI;
                else if (p_type == EXT_GROUPS && p_body >= 2)
                    nx = PH_GRP_LEN_HI;
                else if (p_type == EXT_POINTS)
                    nx = PH_PF_LEN;
                else if (p_type == EXT_VERSIONS)
                    nx = PH_SV_LEN;
                else
                    nx = PH_BODY_SKIP;
            end
            PH_GRP_LEN_HI: begin p_held = b; nx = PH_GRP_LEN_LO; end
            PH_GRP_LEN_LO: begin p_list = v; nx = PH_GRP_HI; end
            PH_GRP_HI, PH_SV_HI:
            begin
                if (p_list < 2)
                    nx = PH_BODY_SKIP;
                else
                begin
                    p_list = p_list - 16'd2;
                    p_held = b;
                    nx = (ph == PH_GRP_HI) ? PH_GRP_LO : PH_SV_LO;
                end
            end
            PH_GRP_LO:
            begin
                if (!grease(v))
                    emit(KIND_CURVE, v, 1'b0, STATUS_OK, 1'b0);
                nx = PH_GRP_HI;
            end
            PH_SV_LO:
            begin
                if (v == VER_TLS13)
                    p_tls13 = 1'b1;
                nx = PH_SV_HI;
            end
            PH_PF_LEN: begin p_list = {8'h0, b}; nx = PH_PF; end
            PH_SV_LEN: begin p_list = {8'h0, b}; nx = PH_SV_HI; end
            PH_PF:
            begin
                if (p_list == 0)
                    nx = PH_BODY_SKIP;
                else
                begin
                    p_list = p_list - 16'd1;
                    emit(KIND_POINT, {8'h0, b}, 1'b0, STATUS_OK, 1'b0);
                end
            end
            default: ;
        endcase
        if (in_body && p_body == 0)
            nx = PH_ET_HI;
        if (p_ext == 0)
            nx = PH_DONE;
        p_phase = nx;
    endfunction

    // Advances the shadow parser by one byte; tokens land in new_tokens.
    function automatic void parse_record_byte(input logic [7:0] b, input logic fin);
        logic [1:0] st;
        new_tokens.delete();
        case (p_phase)
            PH_FIXED:
            begin
                if ((p_offset == 0 && b != REC_HANDSHAKE)
                    || (p_offset == 5 && b != HS_CLIENT_HELLO))
                begin
                    p_status = STATUS_NOT_HELLO;
                    p_phase  = PH_REJECT;
                end
                else
                begin
                    if (p_offset == 9)
                        p_held = b;
                    if (p_offset == 10)
                        emit(KIND_VERSION, {p_held, b}, 1'b0, STATUS_OK, 1'b0);
                    if (p_offset == 43)
                    begin
                        p_section = {8'h0, b};
                        p_phase = (b != 0) ? PH_SID : PH_CSLEN_HI;
                    end
                    if (p_offset != 16'hffff)
                        p_offset = p_offset + 16'd1;
                end
            end
            PH_SID, PH_COMP:
            begin
                p_section = p_section - 16'd1;
                if (p_section == 0)
                    p_phase = (p_phase == PH_SID) ? PH_CSLEN_HI : PH_EXTLEN_HI;
            end
            PH_CSLEN_HI: begin p_held = b; p_phase = PH_CSLEN_LO; end
            PH_EXTLEN_HI: begin p_held = b; p_phase = PH_EXTLEN_LO; end
            PH_CSLEN_LO:
            begin
                p_section = {p_held, b};
                p_phase = (p_section != 0) ? PH_CS_HI : PH_COMP_LEN;
            end
            PH_CS_HI:
            begin
                p_section = p_section - 16'd1;
                p_held = b;
                p_phase = (p_section != 0) ? PH_CS_LO : PH_COMP_LEN;
            end
            PH_CS_LO:
            begin
                p_section = p_section - 16'd1;
                if (!grease({p_held, b}))
                    emit(KIND_CIPHER, {p_held, b}, 1'b0, STATUS_OK, 1'b0);
                p_phase = (p_section != 0) ? PH_CS_HI : PH_COMP_LEN;
            end
            PH_COMP_LEN:
            begin
                p_section = {8'h0, b};
                p_phase = (b != 0) ? PH_COMP : PH_EXTLEN_HI;
            end
            PH_EXTLEN_LO:
            begin
                p_ext = {p_held, b};
                p_phase = (p_ext != 0) ? PH_ET_HI : PH_DONE;
            end
            default:
                if (p_phase >= PH_ET_HI && p_phase <= PH_SV_LO)
                    extension_byte(b);
        endcase
        if (fin)
        begin
            st = p_status;
            if (st == STATUS_OK && p_phase < PH_COMP_LEN)
                st = STATUS_TRUNC;
            emit(KIND_END, 16'h0, 1'b1, st, p_tls13);
            clear_parser();
        end
    endfunction

    // Drives one byte and returns once it has been transferred.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(negedge clk);
        end
        byte_in.valid     <= 1'b1;
        byte_in.data_byte <= b;
        byte_in.is_final  <= fin;
        do
            @(posedge clk);
        while (!byte_in.ready);
        bytes_sent++;
    endtask

    task automatic send_predicted(input logic [7:0] b, input logic fin);
        send_byte(b, fin);
        parse_record_byte(b, fin);
        foreach (new_tokens[i])
            pending_tokens.push_back(new_tokens[i]);
    endtask

    function automatic logic [15:0] random_grease();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        return {n, 4'ha, n, 4'ha};
    endfunction

    function automatic void put16(input logic [15:0] v);
        record_bytes.push_back(v[15:8]);
        record_bytes.push_back(v[7:0]);
    endfunction

    // Builds a ClientHello with random content, sometimes damaged.
    function automatic void build_record();
        logic [7:0]  ext_block [$];
        logic [7:0]  body [$];
        logic [15:0] ext_type, v;
        int          n, len, cut;
        record_bytes.delete();
        record_bytes.push_back($urandom_range(99) < 5 ? 8'($urandom) : REC_HANDSHAKE);
        put16(16'h0301);
        put16(16'($urandom_range(512)));
        record_bytes.push_back($urandom_range(99) < 5 ? 8'($urandom) : HS_CLIENT_HELLO);
        record_bytes.push_back(8'h00);
        put16(16'($urandom_range(508)));
        put16($urandom_range(1) ? 16'h0303 : 16'($urandom));
        repeat (32)
            record_bytes.push_back(8'($urandom));
        n = $urandom_range(3) == 0 ? $urandom_range(1, 6) : 0;
        record_bytes.push_back(8'(n));
        repeat (n)
            record_bytes.push_back(8'($urandom));
        n = $urandom_range(12);
        put16(16'(n));
        for (int i = 0; i < n; i += 2)
        begin
            v = $urandom_range(4) == 0 ? random_grease() : 16'($urandom);
            record_bytes.push_back(v[15:8]);
            if (i + 1 < n)
                record_bytes.push_back(v[7:0]);
        end
        n = $urandom_range(2);
        record_bytes.push_back(8'(n));
        repeat (n)
            record_bytes.push_back(8'($urandom));
        repeat ($urandom_range(4))
        begin
            body.delete();
            case ($urandom_range(5))
                0: ext_type = EXT_GROUPS;
                1: ext_type = EXT_POINTS;
                2: ext_type = EXT_VERSIONS;
                3: ext_type = random_grease();
                default: ext_type = 16'($urandom);
            endcase
            if (ext_type == EXT_GROUPS)
            begin
                n = 2 * $urandom_range(3);
                body.push_back(8'h00);
                body.push_back(8'(n + ($urandom_range(4) == 0 ? 1 : 0)));
                repeat (n / 2)
                begin
                    v = $urandom_range(3) == 0 ? random_grease() : 16'($urandom);
                    body.push_back(v[15:8]);
                    body.push_back(v[7:0]);
                end
            end
            else if (ext_type == EXT_POINTS)
            begin
                n = $urandom_range(3);
                body.push_back(8'(n));
                repeat (n)
                    body.push_back($urandom_range(3) == 0 ? 8'h0a : 8'($urandom));
            end
            else if (ext_type == EXT_VERSIONS)
            begin
                n = 2 * $urandom_range(3) + ($urandom_range(4) == 0 ? 1 : 0);
                body.push_back(8'(n));
                for (int i = 0; i < n; i += 2)
                begin
                    case ($urandom_range(2))
                        0: v = VER_TLS13;
                        1: v = random_grease();
                        default: v = 16'h0303;
                    endcase
                    body.push_back(v[15:8]);
                    if (i + 1 < n)
                        body.push_back(v[7:0]);
                end
            end
            else
                repeat ($urandom_range(3))
                    body.push_back(8'($urandom));
            len = body.size();
            // Now and then the declared length is redrawn and may disagree with the body.
            if ($urandom_range(6) == 0)
                len = $urandom_range(len + 2);
            ext_block.push_back(ext_type[15:8]);
            ext_block.push_back(ext_type[7:0]);
            ext_block.push_back(8'(len >> 8));
            ext_block.push_back(8'(len));
            foreach (body[i])
                ext_block.push_back(body[i]);
        end
        len = ext_block.size();
        if ($urandom_range(6) == 0)
            len = $urandom_range(len + 3);
        if (len != 0 || $urandom_range(1))
            put16(16'(len));
        foreach (ext_block[i])
            record_bytes.push_back(ext_block[i]);
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 3))
                record_bytes.push_back(8'($urandom));
        if ($urandom_range(4) == 0)
        begin
            cut = $urandom_range(1, record_bytes.size());
            while (record_bytes.size() > cut)
                void'(record_bytes.pop_back());
        end
    endfunction

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            tok_out.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            tok_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && tok_out.valid && tok_out.ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token with no expectation: kind %0d value %h",
                       tok_out.token_kind, tok_out.token_value);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (tok_out.token_kind !== want.token_kind)
                begin
                    $error("token_kind: expected %0d, got %0d",
                           want.token_kind, tok_out.token_kind);
                    mismatches++;
                end
                if (tok_out.token_value !== want.token_value)
                begin
                    $error("token_value: expected %h, got %h",
                           want.token_value, tok_out.token_value);
                    mismatches++;
                end
                if (tok_out.end_of_record !== want.end_of_record)
                begin
                    $error("end_of_record: expected %0d, got %0d",
                           want.end_of_record, tok_out.end_of_record);
                    mismatches++;
                end
                if (tok_out.parse_status !== want.parse_status)
                begin
                    $error("parse_status: expected %0d, got %0d",
                           want.parse_status, tok_out.parse_status);
                    mismatches++;
                end
                if (tok_out.offers_tls13 !== want.offers_tls13)
                begin
                    $error("offers_tls13: expected %0d, got %0d",
                           want.offers_tls13, tok_out.offers_tls13);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int records;
        logic fin;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = 8'h00;
        byte_in.is_final  = 1'b0;
        tok_out.ready     = 1'b0;
        rst_n = 1'b0;
        clear_parser();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Typed rows take the written token; the shadow parser still steps.
        for (int r = 0; r < NUM_DIR; r++)
        begin
            send_byte(dir_rows[r].data, dir_rows[r].fin);
            parse_record_byte(dir_rows[r].data, dir_rows[r].fin);
            if (dir_rows[r].has_tok)
                pending_tokens.push_back(dir_rows[r].tok);
        end

        records = 0;
        while (bytes_sent < 720)
        begin
            if (bytes_sent < 270)
            begin
                tx_idle_pct = 7;
                rx_idle_pct = 70;
            end
            else if (bytes_sent < 520)
            begin
                tx_idle_pct = 70;
                rx_idle_pct = 7;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            build_record();
            records++;
            // A long receiver stall while bytes keep coming fills the token queue.
            if (records == 5)
                hold_cycles = 150;
            // Once, hold the stream until every token has been seen.
            if (records == 8)
            begin
                @(negedge clk);
                byte_in.valid <= 1'b0;
                wait (pending_tokens.size() == 0);
                repeat (5) @(posedge clk);
            end
            foreach (record_bytes[i])
            begin
                fin = (i == record_bytes.size() - 1);
                send_predicted(record_bytes[i], fin);
            end
        end
        @(negedge clk);
        byte_in.valid <= 1'b0;
        wait (pending_tokens.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
